[rtl/bdpc_pkg.sv]
package bdpc_pkg;

   localparam int NUM_BUTTONS = 4;
   localparam int BTN_W       = $clog2(NUM_BUTTONS);
   localparam int PIN_W       = 4;
   localparam int TIME_W      = 32;
   localparam int SHORT_W     = 16;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 32;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic [BTN_W-1:0] BTN_LAST = BTN_W'(NUM_BUTTONS - 1);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_PRESS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STUCK_RESET = 2'd2;

   localparam logic [SHORT_W-1:0] DEBOUNCE_RESET    = 16'd50;
   localparam logic [SHORT_W-1:0] LONG_PRESS_RESET  = 16'd1000;
   localparam logic [TIME_W-1:0]  STUCK_RESET_RESET = 32'd10000;

   typedef struct packed {
      logic [SHORT_W-1:0] debounce_ms;
      logic [SHORT_W-1:0] long_press_ms;
      logic [TIME_W-1:0]  stuck_reset_ms;
   } cfg_type;

   typedef struct packed {
      logic [BTN_W-1:0]  button;
      logic              is_long;
      logic [TIME_W-1:0] duration_ms;
      logic              last;
   } event_type;

   typedef struct packed {
      logic      push;
      event_type beat;
   } push_type;

   typedef enum logic [1:0] {
      STEP_IDLE,
      STEP_MAIN,
      STEP_STUCK
   } step_type;

endpackage

[rtl/button_debounce_press_classifier.sv]
// Takes button samples: for each sample, each of the 4 buttons gets a main
// step (debounce, release, long press) and a stuck-press step, one per cycle
// unless the event queue is full; the next sample can be taken in the last step.
// Events go through a 4-deep queue, so a short output stall does not block input.
// Synchronous active-high reset: all buttons released, registers at 50/1000/10000,
// queue and output empty; ready for a sample in the first cycle after reset.
module button_debounce_press_classifier import bdpc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [TIME_W-1:0]     req_now_ms,
   input  logic [PIN_W-1:0]      req_pin_levels,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [BTN_W-1:0]      rsp_button,
   output logic                  rsp_is_long,
   output logic [TIME_W-1:0]     rsp_duration_ms,
   output logic                  rsp_last
);

   cfg_type  cfg_ff;
   push_type push;
   logic     queue_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms    <= DEBOUNCE_RESET;
         cfg_ff.long_press_ms  <= LONG_PRESS_RESET;
         cfg_ff.stuck_reset_ms <= STUCK_RESET_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_DEBOUNCE:    cfg_ff.debounce_ms    <= csr_wdata[SHORT_W-1:0];
            CSR_LONG_PRESS:  cfg_ff.long_press_ms  <= csr_wdata[SHORT_W-1:0];
            CSR_STUCK_RESET: cfg_ff.stuck_reset_ms <= csr_wdata[TIME_W-1:0];
            default: ;
         endcase
      end
   end

   bdpc_front u_front (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_now_ms     (req_now_ms),
      .req_pin_levels (req_pin_levels),
      .push           (push),
      .queue_full     (queue_full)
   );

   bdpc_back u_back (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .queue_full      (queue_full),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_button      (rsp_button),
      .rsp_is_long     (rsp_is_long),
      .rsp_duration_ms (rsp_duration_ms),
      .rsp_last        (rsp_last)
   );

endmodule

[rtl/bdpc_front.sv]
module bdpc_front import bdpc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [TIME_W-1:0] req_now_ms,
   input  logic [PIN_W-1:0]  req_pin_levels,
   output push_type          push,
   input  logic              queue_full
);

   step_type          state_ff, state_in;
   logic [BTN_W-1:0]  btn_ff, btn_in;
   logic [TIME_W-1:0] now_ff;
   logic [PIN_W-1:0]  pins_ff;

   logic [NUM_BUTTONS-1:0] raw_prev_ff;
   logic [NUM_BUTTONS-1:0] stable_ff;
   logic [NUM_BUTTONS-1:0] held_ff;
   logic [NUM_BUTTONS-1:0] long_fired_ff;
   logic [TIME_W-1:0]      change_time_ff [NUM_BUTTONS];
   logic [TIME_W-1:0]      press_time_ff  [NUM_BUTTONS];

   event_type pend_ff;
   logic      pend_valid_ff;
   logic      pend_final_ff;

   logic              cur, raw_chg, stable_flip, press_start, release_end;
   logic [TIME_W-1:0] change_sel, since_change, held_dur, dur_main;
   logic [TIME_W-1:0] long_ms, stuck_ms;
   logic              held_main, lf_main, long_hit, short_rel;
   logic              stuck_hit, stuck_clear, stuck_evt;
   logic              ev_valid, last_step, push_pend, block, advance, accept;
   event_type         ev;

   assign long_ms  = TIME_W'(cfg.long_press_ms);
   assign stuck_ms = cfg.stuck_reset_ms;

   // per-button step: debounce, release and long checks in the main step, stuck checks in the stuck step
   always_comb begin
      cur          = pins_ff[btn_ff];
      raw_chg      = cur != raw_prev_ff[btn_ff];
      change_sel   = raw_chg ? now_ff : change_time_ff[btn_ff];
      since_change = now_ff - change_sel;
      stable_flip  = (since_change >= TIME_W'(cfg.debounce_ms)) && (stable_ff[btn_ff] != cur);
      press_start  = stable_flip && !cur;
      release_end  = stable_flip && cur && held_ff[btn_ff];
      held_dur     = now_ff - press_time_ff[btn_ff];
      dur_main     = press_start ? '0 : held_dur;
      held_main    = press_start || (held_ff[btn_ff] && !release_end);
      lf_main      = !(press_start || release_end) && long_fired_ff[btn_ff];
      long_hit     = held_main && !lf_main && (dur_main >= long_ms);
      short_rel    = release_end && (held_dur < long_ms);
      stuck_hit    = held_ff[btn_ff] && (held_dur > stuck_ms);
      stuck_clear  = stuck_hit && cur;
      stuck_evt    = stuck_clear && (stuck_ms < long_ms);
   end

   always_comb begin
      ev.button = btn_ff;
      ev.last   = 1'b0;
      ev_valid  = 1'b0;
      ev.is_long     = 1'b0;
      ev.duration_ms = held_dur;
      if (state_ff == STEP_MAIN) begin
         if (short_rel) begin
            ev_valid = 1'b1;
         end else if (long_hit) begin
            ev_valid       = 1'b1;
            ev.is_long     = 1'b1;
            ev.duration_ms = dur_main;
         end
      end else if (state_ff == STEP_STUCK) begin
         if (stuck_evt) begin
            ev_valid       = 1'b1;
            ev.duration_ms = stuck_ms;
         end
      end
   end

   // one event is held back so that the last beat of a sample can be flagged
   assign last_step = (state_ff == STEP_STUCK) && (btn_ff == BTN_LAST);
   assign push_pend = pend_valid_ff && (pend_final_ff || ev_valid || last_step);
   assign block     = push_pend && queue_full;
   assign advance   = !block;
   assign req_stall = block || !((state_ff == STEP_IDLE) || last_step);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      push.push      = push_pend && !queue_full;
      push.beat      = pend_ff;
      push.beat.last = pend_final_ff || (last_step && !ev_valid);
   end

   always_comb begin
      state_in = state_ff;
      btn_in   = btn_ff;
      unique case (state_ff)
         STEP_IDLE: begin
            if (accept) begin
               state_in = STEP_MAIN;
               btn_in   = '0;
            end
         end
         STEP_MAIN: begin
            if (advance) begin
               state_in = STEP_STUCK;
            end
         end
         STEP_STUCK: begin
            if (advance) begin
               if (btn_ff == BTN_LAST) begin
                  state_in = accept ? STEP_MAIN : STEP_IDLE;
                  btn_in   = '0;
               end else begin
                  state_in = STEP_MAIN;
                  btn_in   = btn_ff + BTN_W'(1);
               end
            end
         end
         default: begin
            state_in = STEP_IDLE;
            btn_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STEP_IDLE;
         btn_ff   <= '0;
      end else begin
         state_ff <= state_in;
         btn_ff   <= btn_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         now_ff  <= req_now_ms;
         pins_ff <= req_pin_levels;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_prev_ff   <= '1;
         stable_ff     <= '1;
         held_ff       <= '0;
         long_fired_ff <= '0;
         for (int i = 0; i < NUM_BUTTONS; i++) begin
            change_time_ff[i] <= '0;
            press_time_ff[i]  <= '0;
         end
      end else if (advance) begin
         if (state_ff == STEP_MAIN) begin
            raw_prev_ff[btn_ff]    <= cur;
            change_time_ff[btn_ff] <= change_sel;
            if (stable_flip) begin
               stable_ff[btn_ff] <= cur;
            end
            held_ff[btn_ff]       <= held_main;
            long_fired_ff[btn_ff] <= lf_main || long_hit;
            if (press_start) begin
               press_time_ff[btn_ff] <= now_ff;
            end
         end else if (state_ff == STEP_STUCK) begin
            if (stuck_clear) begin
               held_ff[btn_ff]       <= 1'b0;
               long_fired_ff[btn_ff] <= 1'b0;
               press_time_ff[btn_ff] <= '0;
            end else if (stuck_hit) begin
               press_time_ff[btn_ff] <= now_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         pend_final_ff <= 1'b0;
      end else if (advance) begin
         if (ev_valid) begin
            pend_valid_ff <= 1'b1;
            pend_final_ff <= last_step;
         end else if (push_pend) begin
            pend_valid_ff <= 1'b0;
            pend_final_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && ev_valid) begin
         pend_ff <= ev;
      end
   end

endmodule

[rtl/bdpc_back.sv]
module bdpc_back import bdpc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  push_type          push,
   output logic              queue_full,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [BTN_W-1:0]  rsp_button,
   output logic              rsp_is_long,
   output logic [TIME_W-1:0] rsp_duration_ms,
   output logic              rsp_last
);

   event_type          queue_mem [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]    count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   event_type          rsp_beat_ff;
   logic               pop, do_push;

   assign queue_full = count_ff == (QPTR_W + 1)'(QUEUE_DEPTH);
   assign do_push    = push.push && !queue_full;
   assign pop        = (count_ff != '0) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      wr_ptr_in    = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in    = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in     = count_ff + (QPTR_W + 1)'(do_push) - (QPTR_W + 1)'(pop);
      rsp_valid_in = pop || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         queue_mem[wr_ptr_ff] <= push.beat;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_beat_ff <= queue_mem[rd_ptr_ff];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_button      = rsp_beat_ff.button;
   assign rsp_is_long     = rsp_beat_ff.is_long;
   assign rsp_duration_ms = rsp_beat_ff.duration_ms;
   assign rsp_last        = rsp_beat_ff.last;

endmodule

[rtl/bdpc_checker.sv]
module bdpc_checker import bdpc_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [BTN_W-1:0]  rsp_button,
   input logic              rsp_is_long,
   input logic [TIME_W-1:0] rsp_duration_ms,
   input logic              rsp_last
);

   // a stalled beat stays put
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_button) && $stable(rsp_is_long)
         && $stable(rsp_duration_ms) && $stable(rsp_last))
      else $error("stalled response beat changed");

   // out of reset nothing is pending and a sample can be taken
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid && !req_stall)
      else $error("block not empty after reset");

   // an accepted sample occupies the button sequencer, which then stalls requests
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("sample taken while sequencer busy");

   // an accepted sample keeps the sequencer busy and stalling further requests
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> ##1 req_stall)
      else $error("sequencer finished a sample too early");

endmodule

bind button_debounce_press_classifier bdpc_checker u_checker (.*);

[sim/bdpc_event_checker.sv]
module bdpc_event_checker import bdpc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic [TIME_W-1:0]     req_now_ms,
   input  logic [PIN_W-1:0]      req_pin_levels,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic [BTN_W-1:0]      rsp_button,
   input  logic                  rsp_is_long,
   input  logic [TIME_W-1:0]     rsp_duration_ms,
   input  logic                  rsp_last,
   output int                    fail_count,
   output int                    pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_EVENTS   = 8;
   localparam int REPORT_LIMIT = 10;

   cfg_type                cfg;
   logic [NUM_BUTTONS-1:0] raw_prev;
   logic [NUM_BUTTONS-1:0] stable_lvl;
   logic [NUM_BUTTONS-1:0] held;
   logic [NUM_BUTTONS-1:0] long_fired;
   logic [TIME_W-1:0]      change_t [NUM_BUTTONS];
   logic [TIME_W-1:0]      press_t  [NUM_BUTTONS];
   event_type              expected_events [$];
   int                     beats_seen;

   // events past the per-sample cap are silently dropped
   function automatic void add_event(ref event_type evs [$], input int b,
                                     input logic lng, input logic [TIME_W-1:0] dur);
      event_type ev;
      if (evs.size() < MAX_EVENTS) begin
         ev.button      = BTN_W'(b);
         ev.is_long     = lng;
         ev.duration_ms = dur;
         ev.last        = 1'b0;
         evs.push_back(ev);
      end
   endfunction

   task automatic predict_sample(input logic [TIME_W-1:0] now, input logic [PIN_W-1:0] pins);
      event_type         evs [$];
      event_type         ev;
      logic              lvl;
      logic [TIME_W-1:0] held_for;
      for (int b = 0; b < NUM_BUTTONS; b++) begin
         lvl = (b < PIN_W) ? pins[b] : 1'b0;
         if (lvl != raw_prev[b]) begin
            change_t[b] = now;
            raw_prev[b] = lvl;
         end
         held_for = now - change_t[b];
         if (held_for >= TIME_W'(cfg.debounce_ms) && stable_lvl[b] != lvl) begin
            stable_lvl[b] = lvl;
            if (!lvl) begin
               held[b]       = 1'b1;
               press_t[b]    = now;
               long_fired[b] = 1'b0;
            end else if (held[b]) begin
               held_for = now - press_t[b];
               if (held_for < TIME_W'(cfg.long_press_ms))
                  add_event(evs, b, 1'b0, held_for);
               held[b]       = 1'b0;
               long_fired[b] = 1'b0;
            end
         end
         held_for = now - press_t[b];
         if (held[b] && !long_fired[b] && held_for >= TIME_W'(cfg.long_press_ms)) begin
            add_event(evs, b, 1'b1, held_for);
            long_fired[b] = 1'b1;
         end
         // stuck press: clear it if the pin is up, else restart the press clock
         if (held[b] && held_for > cfg.stuck_reset_ms) begin
            if (lvl) begin
               if (cfg.stuck_reset_ms < TIME_W'(cfg.long_press_ms))
                  add_event(evs, b, 1'b0, cfg.stuck_reset_ms);
               held[b]       = 1'b0;
               long_fired[b] = 1'b0;
               press_t[b]    = '0;
            end else begin
               press_t[b] = now;
            end
         end
      end
      if (evs.size() > 0) begin
         ev      = evs.pop_back();
         ev.last = 1'b1;
         evs.push_back(ev);
      end
      foreach (evs[k])
         expected_events.push_back(evs[k]);
   endtask

   task automatic check_beat();
      event_type want;
      if (expected_events.size() == 0) begin
         fail_count++;
         if (fail_count <= REPORT_LIMIT)
            $display("ERROR: beat %0d unexpected: button %0d is_long %0b duration %0d last %0b",
                     beats_seen, rsp_button, rsp_is_long, rsp_duration_ms, rsp_last);
      end else begin
         want = expected_events.pop_front();
         if (rsp_button !== want.button || rsp_is_long !== want.is_long ||
             rsp_duration_ms !== want.duration_ms || rsp_last !== want.last) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT) begin
               $display("ERROR: beat %0d expected button %0d is_long %0b duration %0d last %0b",
                        beats_seen, want.button, want.is_long, want.duration_ms, want.last);
               $display("       beat %0d got      button %0d is_long %0b duration %0d last %0b",
                        beats_seen, rsp_button, rsp_is_long, rsp_duration_ms, rsp_last);
            end
         end
      end
      beats_seen++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg.debounce_ms    = DEBOUNCE_RESET;
         cfg.long_press_ms  = LONG_PRESS_RESET;
         cfg.stuck_reset_ms = STUCK_RESET_RESET;
         raw_prev   = '1;
         stable_lvl = '1;
         held       = '0;
         long_fired = '0;
         for (int b = 0; b < NUM_BUTTONS; b++) begin
            change_t[b] = '0;
            press_t[b]  = '0;
         end
         expected_events.delete();
         fail_count = 0;
         beats_seen = 0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_DEBOUNCE:    cfg.debounce_ms    = csr_wdata[SHORT_W-1:0];
               CSR_LONG_PRESS:  cfg.long_press_ms  = csr_wdata[SHORT_W-1:0];
               CSR_STUCK_RESET: cfg.stuck_reset_ms = csr_wdata[TIME_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            predict_sample(req_now_ms, req_pin_levels);
         if (rsp_valid && !rsp_stall)
            check_beat();
      end
      pending = expected_events.size();
   end

endmodule

[sim/tb_top.sv]
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import bdpc_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   localparam int STALL_LIMIT   = 4000;
   localparam int DRAIN_CYCLES  = 24;
   localparam int HOLD_CYCLES   = 300;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_SAMPLES = 50;

   typedef enum {RX_READY, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_write_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   logic                  req_valid;
   logic                  req_stall;
   logic [TIME_W-1:0]     req_now_ms;
   logic [PIN_W-1:0]      req_pin_levels;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [BTN_W-1:0]      rsp_button;
   logic                  rsp_is_long;
   logic [TIME_W-1:0]     rsp_duration_ms;
   logic                  rsp_last;

   int fail_count;
   int pending;
   int burst_left;
   bit gaps_on;
   int hold_requests;
   int idle_cycles;

   button_debounce_press_classifier dut (
      .clock           (clock),
      .reset           (reset),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_now_ms      (req_now_ms),
      .req_pin_levels  (req_pin_levels),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_button      (rsp_button),
      .rsp_is_long     (rsp_is_long),
      .rsp_duration_ms (rsp_duration_ms),
      .rsp_last        (rsp_last)
   );

   bdpc_event_checker u_event_check (
      .clock           (clock),
      .reset           (reset),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_now_ms      (req_now_ms),
      .req_pin_levels  (req_pin_levels),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_button      (rsp_button),
      .rsp_is_long     (rsp_is_long),
      .rsp_duration_ms (rsp_duration_ms),
      .rsp_last        (rsp_last),
      .fail_count      (fail_count),
      .pending         (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // sender side: with gaps on, bursts of samples separated by random gaps
   task automatic send_sample(input logic [TIME_W-1:0] stamp, input logic [PIN_W-1:0] pins);
      @(negedge clock);
      if (gaps_on) begin
         if (burst_left == 0) begin
            req_valid = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clock);
            burst_left = $urandom_range(1, 12);
         end
         burst_left--;
      end
      req_valid      = 1'b1;
      req_now_ms     = stamp;
      req_pin_levels = pins;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_write_en = 1'b1;
      csr_index    = idx;
      csr_wdata    = data;
      @(negedge clock);
      csr_write_en = 1'b0;
   endtask

   // drain all events, then give the last sample time to finish its button steps
   task automatic quiesce();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // receiver side: stall pattern changes every so often; long hold-off on request
   initial begin
      rx_mode_type mode;
      int          mode_left;
      int          hold_left;
      int          holds_done;
      int          phase_cnt;
      rsp_stall  = 1'b0;
      mode       = RX_READY;
      mode_left  = 0;
      hold_left  = 0;
      holds_done = 0;
      phase_cnt  = 0;
      forever begin
         @(negedge clock);
         if (hold_requests != holds_done) begin
            holds_done++;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_stall = 1'b1;
            hold_left--;
         end else begin
            if (mode_left == 0) begin
               mode      = rx_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(20, 150);
            end
            mode_left--;
            phase_cnt++;
            case (mode)
               RX_READY:    rsp_stall = 1'b0;
               RX_LIGHT:    rsp_stall = ($urandom_range(0, 2) == 0);
               RX_HEAVY:    rsp_stall = ($urandom_range(0, 3) != 0);
               RX_PERIODIC: rsp_stall = ((phase_cnt % 5) < 2);
               default:     rsp_stall = 1'b0;
            endcase
         end
      end
   end

   initial begin
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write_en)
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("button_debounce_press_classifier: mismatch");
      $finish;
   end

   initial begin
      logic [TIME_W-1:0]  now_ms;
      logic [PIN_W-1:0]   phys;
      logic [PIN_W-1:0]   pins;
      logic [SHORT_W-1:0] deb;
      logic [SHORT_W-1:0] lng;
      logic [TIME_W-1:0]  stk;
      int                 step_max;
      int                 roll;

      reset          = 1'b1;
      csr_write_en   = 1'b0;
      csr_index      = CSR_DEBOUNCE;
      csr_wdata      = '0;
      req_valid      = 1'b0;
      req_now_ms     = '0;
      req_pin_levels = '1;
      hold_requests  = 0;
      burst_left     = 0;
      gaps_on        = 1'b1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset settings, all buttons up, both timestamp extremes
      send_sample(32'd0, 4'b1111);
      send_sample(32'hFFFF_FFFF, 4'b1111);

      // press that becomes stable exactly at time zero
      quiesce();
      csr_write(CSR_DEBOUNCE, 32'd0);
      send_sample(32'd0, 4'b1110);
      send_sample(32'd30, 4'b1111);

      // zero long-press time: long event on the same sample as the press
      quiesce();
      csr_write(CSR_LONG_PRESS, 32'd0);
      send_sample(32'd100, 4'b0000);
      send_sample(32'd150, 4'b1111);

      // press across the timestamp wrap; upper bits of a 16-bit register ignored
      quiesce();
      csr_write(CSR_LONG_PRESS, 32'hABCD_03E8);
      csr_write(CSR_DEBOUNCE, 32'd10);
      send_sample(32'hFFFF_FFF0, 4'b1101);
      send_sample(32'hFFFF_FFFF, 4'b1101);
      send_sample(32'd400, 4'b1111);
      send_sample(32'd416, 4'b1111);

      // all four stuck while the release is still bouncing: eight events at once
      quiesce();
      csr_write(CSR_LONG_PRESS, 32'd2000);
      csr_write(CSR_STUCK_RESET, 32'd100);
      csr_write(CSR_DEBOUNCE, 32'd0);
      send_sample(32'd1000, 4'b0000);
      quiesce();
      csr_write(CSR_DEBOUNCE, 32'h1234_FFFF);
      send_sample(32'd1050, 4'b1111);
      hold_requests++;
      send_sample(32'd3100, 4'b1111);
      send_sample(32'd3150, 4'b1111);
      send_sample(32'd3200, 4'b0000);
      send_sample(32'd3250, 4'b0000);

      // stuck while still down restarts the press clock; spare index is a no-op
      quiesce();
      csr_write(CSR_DEBOUNCE, 32'd0);
      csr_write(CSR_LONG_PRESS, 32'h0000_FFFF);
      csr_write(CSR_STUCK_RESET, 32'd1);
      csr_write(CSR_SPARE, 32'hFFFF_FFFF);
      send_sample(32'd5000, 4'b1111);
      send_sample(32'd5000, 4'b0111);
      send_sample(32'd5002, 4'b0111);
      send_sample(32'd5010, 4'b1111);

      now_ms = 32'hFFFF_F000;
      phys   = 4'b1111;
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         quiesce();
         gaps_on = ($urandom_range(0, 3) != 0);
         case (p)
            0: begin
               deb = '0;
               lng = 16'd1;
               stk = 32'd1;
            end
            1: begin
               deb = '1;
               lng = '1;
               stk = '1;
            end
            default: begin
               deb = SHORT_W'($urandom_range(0, 24));
               lng = SHORT_W'($urandom_range(1, 160));
               stk = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(1, 320);
            end
         endcase
         csr_write(CSR_DEBOUNCE, {SHORT_W'($urandom()), deb});
         csr_write(CSR_LONG_PRESS, {SHORT_W'($urandom()), lng});
         csr_write(CSR_STUCK_RESET, stk);
         if (p % 3 == 0)
            csr_write(CSR_SPARE, $urandom());
         step_max = ((deb > lng) ? int'(deb) : int'(lng)) / 2 + 4;
         for (int k = 0; k < PHASE_SAMPLES; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 3)
               now_ms = $urandom();
            else
               now_ms = now_ms + TIME_W'($urandom_range(0, step_max));
            if (roll >= 90) begin
               pins = PIN_W'($urandom());
            end else begin
               for (int b = 0; b < PIN_W; b++)
                  if ($urandom_range(0, 3) == 0)
                     phys[b] = ~phys[b];
               pins = phys;
               // contact bounce for this one sample
               if (roll >= 80)
                  pins = pins ^ PIN_W'($urandom());
            end
            send_sample(now_ms, pins);
         end
      end

      @(negedge clock);
      req_valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0 && pending == 0)
         $display("button_debounce_press_classifier: match");
      else
         $display("button_debounce_press_classifier: mismatch");
      $finish;
   end

endmodule
